>>> sv/trsr_pkg.sv
package trsr_pkg;

  // field widths
  localparam int X_W       = 12;
  localparam int Y_W       = 11;
  localparam int COLOR_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int POS_W     = X_W + FRAC_W;   // Q12.16 edge position
  localparam int DX_W      = X_W + 1;        // difference of two x values
  localparam int DY_W      = Y_W + 1;        // difference of two y values
  localparam int DIV_MAG_W = 29;             // dividend / quotient magnitude bits
  localparam int DIV_NUM_W = DIV_MAG_W + 1;  // signed dividend and quotient
  localparam int DEN_W     = Y_W;            // divisor bits (row count below 2048)
  localparam int DIV_CNT_W = $clog2(DIV_MAG_W + 1);

  // edge stepper controls
  typedef struct packed {
    logic load;
    logic step;
    logic down;
  } edge_ctl_t;

endpackage

>>> sv/triangle_scanline_rasterizer_unit.sv
// Channel   Handshake                 Payload
// request   start, busy (in)          first_x/y, second_x/y, third_x/y, fill_color
// result    strobe (out, no stall)    row_y, span_start_x, span_end_x, span_color,
//                                     last_span, too_tall
//
// A triangle is taken when start is high and busy low; busy stays high until its
// last result has gone out. Spans leave one per cycle within a run of rows. Each slope
// takes a pass through the bit-serial divider, two slopes per run of rows; a general
// triangle adds the multiply states S_MUL1 and S_MUL2 and a division for the split vertex.
// Reset is synchronous; results cannot stall.
module triangle_scanline_rasterizer_unit #(
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [trsr_pkg::X_W-1:0]     first_x,
  input  logic signed [trsr_pkg::Y_W-1:0]     first_y,
  input  logic signed [trsr_pkg::X_W-1:0]     second_x,
  input  logic signed [trsr_pkg::Y_W-1:0]     second_y,
  input  logic signed [trsr_pkg::X_W-1:0]     third_x,
  input  logic signed [trsr_pkg::Y_W-1:0]     third_y,
  input  logic        [trsr_pkg::COLOR_W-1:0] fill_color,
  output logic                                strobe,
  output logic signed [trsr_pkg::Y_W-1:0]     row_y,
  output logic signed [trsr_pkg::X_W-1:0]     span_start_x,
  output logic signed [trsr_pkg::X_W-1:0]     span_end_x,
  output logic        [trsr_pkg::COLOR_W-1:0] span_color,
  output logic                                last_span,
  output logic                                too_tall
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int PROD_W = trsr_pkg::X_W + trsr_pkg::DY_W;
  localparam int NUMX_W = PROD_W + 2;
  localparam logic signed [trsr_pkg::DY_W-1:0] TALL_LIM = trsr_pkg::DY_W'(MAX_ROWS - 2);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLASS = 8'b0000_0010,
    S_MUL1  = 8'b0000_0100,
    S_MUL2  = 8'b0000_1000,
    S_DGO   = 8'b0001_0000,
    S_DWT   = 8'b0010_0000,
    S_LOAD  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    J_SX = 3'b001,
    J_S1 = 3'b010,
    J_S2 = 3'b100
  } job_t;

  state_t state;
  job_t   job;

  // sorted vertices
  logic signed [trsr_pkg::X_W-1:0] x0, x1, x2, px, qx;
  logic signed [trsr_pkg::Y_W-1:0] y0, y1, y2;
  logic [trsr_pkg::COLOR_W-1:0]    color;
  logic                            has_b, phase_b;
  logic signed [PROD_W-1:0]        prod;
  logic signed [NUMX_W-1:0]        numx;
  logic signed [trsr_pkg::DIV_NUM_W-1:0] s1;
  logic signed [trsr_pkg::DIV_NUM_W-1:0] s2;
  logic [RW-1:0]                   rows_left;
  logic signed [trsr_pkg::Y_W-1:0] cur_y;

  // stable compare-swap network on the request
  logic signed [trsr_pkg::X_W-1:0] ax0, ax1, ax2, bx0, bx1, bx2, cx0, cx1;
  logic signed [trsr_pkg::Y_W-1:0] ay0, ay1, ay2, by0, by1, by2, cy0, cy1;

  always_comb begin
    if (first_y > second_y) begin
      ax0 = second_x; ay0 = second_y; ax1 = first_x; ay1 = first_y;
    end else begin
      ax0 = first_x; ay0 = first_y; ax1 = second_x; ay1 = second_y;
    end
    ax2 = third_x; ay2 = third_y;
    bx0 = ax0; by0 = ay0;
    if (ay1 > ay2) begin
      bx1 = ax2; by1 = ay2; bx2 = ax1; by2 = ay1;
    end else begin
      bx1 = ax1; by1 = ay1; bx2 = ax2; by2 = ay2;
    end
    if (by0 > by1) begin
      cx0 = bx1; cy0 = by1; cx1 = bx0; cy1 = by0;
    end else begin
      cx0 = bx0; cy0 = by0; cx1 = bx1; cy1 = by1;
    end
  end

  // y differences
  logic signed [trsr_pkg::DY_W-1:0] dy10, dy20, dy21;
  assign dy10 = trsr_pkg::DY_W'(y1) - trsr_pkg::DY_W'(y0);
  assign dy20 = trsr_pkg::DY_W'(y2) - trsr_pkg::DY_W'(y0);
  assign dy21 = trsr_pkg::DY_W'(y2) - trsr_pkg::DY_W'(y1);

  // divider operand selection
  logic signed [trsr_pkg::DX_W-1:0]      dx_sel;
  logic signed [trsr_pkg::DY_W-1:0]      dy_run;
  logic signed [trsr_pkg::DIV_NUM_W-1:0] div_num;
  logic [trsr_pkg::DEN_W-1:0]            div_den;
  logic                                  div_go, div_busy;
  logic signed [trsr_pkg::DIV_NUM_W-1:0] div_quot;

  assign dy_run = phase_b ? dy21 : dy10;

  always_comb begin
    if (!phase_b) begin
      if (job == J_S1) dx_sel = trsr_pkg::DX_W'(x1) - trsr_pkg::DX_W'(x0);
      else             dx_sel = trsr_pkg::DX_W'(qx) - trsr_pkg::DX_W'(x0);
    end else begin
      if (job == J_S1) dx_sel = trsr_pkg::DX_W'(x2) - trsr_pkg::DX_W'(px);
      else             dx_sel = trsr_pkg::DX_W'(x2) - trsr_pkg::DX_W'(qx);
    end
    if (job == J_SX) begin
      div_num = trsr_pkg::DIV_NUM_W'(numx);
      div_den = dy20[trsr_pkg::DEN_W-1:0];
    end else begin
      // dx in Q.16, sign-extended to the dividend width
      div_num = trsr_pkg::DIV_NUM_W'($signed({dx_sel, {trsr_pkg::FRAC_W{1'b0}}}));
      div_den = dy_run[trsr_pkg::DEN_W-1:0];
    end
  end

  assign div_go = (state == S_DGO);

  trsr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quot (div_quot)
  );

  // edge steppers
  trsr_pkg::edge_ctl_t ectl;
  logic signed [trsr_pkg::X_W-1:0] x_run, ex1, ex2;

  assign ectl.load = (state == S_LOAD);
  assign ectl.step = (state == S_EMIT);
  assign ectl.down = phase_b;
  assign x_run     = phase_b ? x2 : x0;

  trsr_edge u_edge1 (
    .clk     (clk),
    .ctl     (ectl),
    .x_start (x_run),
    .slope   (s1),
    .x       (ex1)
  );

  trsr_edge u_edge2 (
    .clk     (clk),
    .ctl     (ectl),
    .x_start (x_run),
    .slope   (s2),
    .x       (ex2)
  );

  assign busy = (state != S_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      job    <= J_S1;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_CLASS;
        end
        S_CLASS: begin
          if (dy20 > TALL_LIM || y0 == y2) begin
            strobe <= 1'b1;
            state  <= S_IDLE;
          end else if (y1 == y2 || y0 == y1) begin
            job   <= J_S1;
            state <= S_DGO;
          end else begin
            job   <= J_SX;
            state <= S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_DGO;
        S_DGO:  state <= S_DWT;
        S_DWT: begin
          if (!div_busy) begin
            unique case (job)
              J_SX: begin job <= J_S1; state <= S_DGO; end
              J_S1: begin job <= J_S2; state <= S_DGO; end
              J_S2: state <= S_LOAD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state <= S_EMIT;
        S_EMIT: begin
          strobe <= 1'b1;
          if (rows_left == RW'(1)) begin
            if (!phase_b && has_b) begin
              job   <= J_S1;
              state <= S_DGO;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          x0 <= cx0; y0 <= cy0; x1 <= cx1; y1 <= cy1; x2 <= bx2; y2 <= by2;
          color <= fill_color;
        end
      end
      S_CLASS: begin
        too_tall     <= 1'b0;
        last_span    <= 1'b1;
        row_y        <= y0;
        span_start_x <= x0;
        span_end_x   <= x0;
        span_color   <= color;
        if (dy20 > TALL_LIM) begin
          too_tall     <= 1'b1;
          row_y        <= '0;
          span_start_x <= '0;
          span_end_x   <= '0;
          span_color   <= '0;
        end
        if (y1 == y2) begin
          // flat bottom: one downward run
          has_b <= 1'b0; phase_b <= 1'b0; qx <= x2;
        end else if (y0 == y1) begin
          // flat top: one upward run from the bottom vertex
          has_b <= 1'b1; phase_b <= 1'b1; px <= x0; qx <= x1;
        end else begin
          has_b <= 1'b1; phase_b <= 1'b0; px <= x1;
        end
      end
      S_MUL1: prod <= x0 * dy20;
      S_MUL2: numx <= NUMX_W'(prod) + NUMX_W'(dy10 * (trsr_pkg::DX_W'(x2) - trsr_pkg::DX_W'(x0)));
      S_DWT: begin
        if (!div_busy) begin
          unique case (job)
            J_SX: qx <= div_quot[trsr_pkg::X_W-1:0];
            J_S1: s1 <= div_quot;
            J_S2: s2 <= div_quot;
            default: s2 <= div_quot;
          endcase
        end
      end
      S_LOAD: begin
        rows_left <= RW'(dy_run + 1'b1);
        cur_y     <= phase_b ? y2 : y0;
      end
      S_EMIT: begin
        row_y        <= cur_y;
        span_start_x <= ex1;
        span_end_x   <= ex2;
        span_color   <= color;
        too_tall     <= 1'b0;
        last_span    <= (rows_left == RW'(1)) && (phase_b || !has_b);
        rows_left    <= rows_left - 1'b1;
        cur_y        <= phase_b ? cur_y - 1'b1 : cur_y + 1'b1;
        if (rows_left == RW'(1) && !phase_b && has_b) phase_b <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/trsr_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, truncates toward zero.
module trsr_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  go,
  input  logic signed [trsr_pkg::DIV_NUM_W-1:0] num,
  input  logic        [trsr_pkg::DEN_W-1:0]     den,
  output logic                                  busy,
  output logic signed [trsr_pkg::DIV_NUM_W-1:0] quot
);

  logic [trsr_pkg::DIV_MAG_W-1:0] mag;
  logic [trsr_pkg::DEN_W-1:0]     rem;
  logic [trsr_pkg::DIV_CNT_W-1:0] cnt;
  logic                           neg;

  logic [trsr_pkg::DIV_NUM_W-1:0] num_abs;
  logic [trsr_pkg::DEN_W:0]       shifted;
  logic [trsr_pkg::DEN_W+1:0]     trial;

  assign num_abs = num[trsr_pkg::DIV_NUM_W-1] ? (~num + 1'b1) : num;
  assign shifted = {rem, mag[trsr_pkg::DIV_MAG_W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, den};

  // restore on negative trial
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= trsr_pkg::DIV_CNT_W'(trsr_pkg::DIV_MAG_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == trsr_pkg::DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      mag <= num_abs[trsr_pkg::DIV_MAG_W-1:0];
      rem <= '0;
      neg <= num[trsr_pkg::DIV_NUM_W-1];
    end else if (busy) begin
      if (!trial[trsr_pkg::DEN_W+1]) begin
        rem <= trial[trsr_pkg::DEN_W-1:0];
        mag <= {mag[trsr_pkg::DIV_MAG_W-2:0], 1'b1};
      end else begin
        rem <= shifted[trsr_pkg::DEN_W-1:0];
        mag <= {mag[trsr_pkg::DIV_MAG_W-2:0], 1'b0};
      end
    end
  end

  assign quot = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

>>> sv/trsr_edge.sv
// One triangle edge: Q12.16 position, saturating step, x truncated toward zero.
module trsr_edge (
  input  logic                                  clk,
  input  trsr_pkg::edge_ctl_t                   ctl,
  input  logic signed [trsr_pkg::X_W-1:0]       x_start,
  input  logic signed [trsr_pkg::DIV_NUM_W-1:0] slope,
  output logic signed [trsr_pkg::X_W-1:0]       x
);

  localparam int SUM_W = trsr_pkg::DIV_NUM_W + 1;
  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((1 << (trsr_pkg::POS_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(1 << (trsr_pkg::POS_W - 1));

  logic signed [trsr_pkg::POS_W-1:0] pos;
  logic signed [SUM_W-1:0]           pos_ext;
  logic signed [SUM_W-1:0]           slope_ext;
  logic signed [SUM_W-1:0]           sum;

  assign pos_ext   = SUM_W'(pos);
  assign slope_ext = SUM_W'(slope);
  assign sum       = ctl.down ? (pos_ext - slope_ext) : (pos_ext + slope_ext);

  // load or step with saturation
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos <= {x_start, {trsr_pkg::FRAC_W{1'b0}}};
    end else if (ctl.step) begin
      if (sum > POS_MAX)      pos <= POS_MAX[trsr_pkg::POS_W-1:0];
      else if (sum < POS_MIN) pos <= POS_MIN[trsr_pkg::POS_W-1:0];
      else                    pos <= sum[trsr_pkg::POS_W-1:0];
    end
  end

  // negative with fraction rounds up to go toward zero
  assign x = pos[trsr_pkg::POS_W-1:trsr_pkg::FRAC_W]
           + trsr_pkg::X_W'(pos[trsr_pkg::POS_W-1] && (|pos[trsr_pkg::FRAC_W-1:0]));

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ROW_LIMIT   = 64;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  DRAIN_WAIT  = 300;
  localparam longint FRAC_ONE = 65536;
  localparam longint POS_LO   = -2048 * 65536;
  localparam longint POS_HI   = 2048 * 65536 - 1;

  typedef struct {
    logic signed [trsr_pkg::X_W-1:0]   x [3];
    logic signed [trsr_pkg::Y_W-1:0]   y [3];
    logic [trsr_pkg::COLOR_W-1:0]      color;
  } tri_req_t;

  typedef struct {
    logic signed [trsr_pkg::Y_W-1:0]   row;
    logic signed [trsr_pkg::X_W-1:0]   xa;
    logic signed [trsr_pkg::X_W-1:0]   xb;
    logic [trsr_pkg::COLOR_W-1:0]      color;
    logic                              last;
    logic                              tall;
  } span_t;

  // span predictor and expected-span store
  class span_scoreboard;
    span_t  pending [$];
    int     mismatches;

    function longint clamp_pos(longint p);
      if (p < POS_LO) return POS_LO;
      if (p > POS_HI) return POS_HI;
      return p;
    endfunction

    function longint slope(longint dx, longint dy);
      if (dy == 0) return 0;
      return (dx * FRAC_ONE) / dy;
    endfunction

    function void walk(longint y0, longint dir, longint rows, longint x0,
                       longint s1, longint s2, logic [trsr_pkg::COLOR_W-1:0] color);
      longint c1, c2;
      span_t  s;
      c1 = x0 * FRAC_ONE;
      c2 = c1;
      for (longint i = 0; i < rows; i++) begin
        s.row   = trsr_pkg::Y_W'(y0 + dir * i);
        s.xa    = trsr_pkg::X_W'(c1 / FRAC_ONE);
        s.xb    = trsr_pkg::X_W'(c2 / FRAC_ONE);
        s.color = color;
        s.last  = 1'b0;
        s.tall  = 1'b0;
        pending.push_back(s);
        c1 = clamp_pos(c1 + dir * s1);
        c2 = clamp_pos(c2 + dir * s2);
      end
    endfunction

    function void note(tri_req_t r);
      longint xs [3], ys [3], t, dy1, dy2, split_x;
      span_t  s;
      for (int i = 0; i < 3; i++) begin
        xs[i] = r.x[i];
        ys[i] = r.y[i];
      end
      // stable three-element sort on y
      for (int i = 0; i < 3; i++) begin
        int j;
        j = (i == 1) ? 1 : 0;
        if (ys[j] > ys[j+1]) begin
          t = ys[j]; ys[j] = ys[j+1]; ys[j+1] = t;
          t = xs[j]; xs[j] = xs[j+1]; xs[j+1] = t;
        end
      end
      if (ys[2] - ys[0] > ROW_LIMIT - 2) begin
        s = '{row: '0, xa: '0, xb: '0, color: '0, last: 1'b1, tall: 1'b1};
        pending.push_back(s);
        return;
      end
      if (ys[0] == ys[2])
        walk(ys[0], 1, 1, xs[0], 0, 0, r.color);
      else if (ys[1] == ys[2])
        walk(ys[0], 1, ys[1] - ys[0] + 1, xs[0], slope(xs[1] - xs[0], ys[1] - ys[0]),
             slope(xs[2] - xs[0], ys[2] - ys[0]), r.color);
      else if (ys[0] == ys[1])
        walk(ys[2], -1, ys[2] - ys[0] + 1, xs[2], slope(xs[2] - xs[0], ys[2] - ys[0]),
             slope(xs[2] - xs[1], ys[2] - ys[1]), r.color);
      else begin
        // split at the middle row, which is emitted by both halves
        dy1 = ys[1] - ys[0];
        dy2 = ys[2] - ys[0];
        split_x = (xs[0] * dy2 + dy1 * (xs[2] - xs[0])) / dy2;
        walk(ys[0], 1, dy1 + 1, xs[0], slope(xs[1] - xs[0], dy1),
             slope(split_x - xs[0], dy1), r.color);
        walk(ys[2], -1, ys[2] - ys[1] + 1, xs[2], slope(xs[2] - xs[1], ys[2] - ys[1]),
             slope(xs[2] - split_x, ys[2] - ys[1]), r.color);
      end
      pending[$].last = 1'b1;
    endfunction

    function void check(span_t got);
      span_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected span: row=%0d xa=%0d xb=%0d", got.row, got.xa, got.xb);
        return;
      end
      e = pending.pop_front();
      if (got.row !== e.row || got.xa !== e.xa || got.xb !== e.xb ||
          got.color !== e.color || got.last !== e.last || got.tall !== e.tall) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("span mismatch: exp row=%0d xa=%0d xb=%0d col=%h last=%b tall=%b",
                   e.row, e.xa, e.xb, e.color, e.last, e.tall);
          $display("               got row=%0d xa=%0d xb=%0d col=%h last=%b tall=%b",
                   got.row, got.xa, got.xb, got.color, got.last, got.tall);
        end
      end
    endfunction
  endclass

  logic clk, rst, start, busy, strobe, last_span, too_tall;
  logic signed [trsr_pkg::X_W-1:0] first_x, second_x, third_x, span_start_x, span_end_x;
  logic signed [trsr_pkg::Y_W-1:0] first_y, second_y, third_y, row_y;
  logic [trsr_pkg::COLOR_W-1:0]    fill_color, span_color;

  span_scoreboard sb;
  int             cycles;
  int             burst_left;

  triangle_scanline_rasterizer_unit #(.MAX_ROWS(ROW_LIMIT)) i_dut (
    .clk, .rst, .start, .busy, .first_x, .first_y, .second_x, .second_y,
    .third_x, .third_y, .fill_color, .strobe, .row_y, .span_start_x,
    .span_end_x, .span_color, .last_span, .too_tall
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // monitor: results first, then accepted requests
  always @(posedge clk) begin
    tri_req_t r;
    if (!rst) begin
      if (strobe)
        sb.check(span_t'{row: row_y, xa: span_start_x, xb: span_end_x, color: span_color,
                         last: last_span, tall: too_tall});
      if (start && !busy) begin
        r.x[0] = first_x;  r.y[0] = first_y;
        r.x[1] = second_x; r.y[1] = second_y;
        r.x[2] = third_x;  r.y[2] = third_y;
        r.color = fill_color;
        sb.note(r);
      end
    end
  end

  // drive one request; bursts of requests sent once busy drops, random gaps between bursts
  task automatic send_tri(tri_req_t r);
    while (busy) begin
      start = 1'b0;
      @(negedge clk);
    end
    first_x  = r.x[0]; first_y  = r.y[0];
    second_x = r.x[1]; second_y = r.y[1];
    third_x  = r.x[2]; third_y  = r.y[2];
    fill_color = r.color;
    start = 1'b1;
    @(negedge clk);
    start = 1'b0;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end else
      burst_left--;
  endtask

  function automatic tri_req_t make_tri(int x0, int y0, int x1, int y1, int x2, int y2);
    tri_req_t r;
    r.x[0] = trsr_pkg::X_W'(x0); r.y[0] = trsr_pkg::Y_W'(y0);
    r.x[1] = trsr_pkg::X_W'(x1); r.y[1] = trsr_pkg::Y_W'(y1);
    r.x[2] = trsr_pkg::X_W'(x2); r.y[2] = trsr_pkg::Y_W'(y2);
    r.color = $urandom;
    return r;
  endfunction

  function automatic int rand_x(bit wide);
    if (wide) return $signed($urandom_range(0, 4095)) - 2048;
    return $signed($urandom_range(0, 200)) - 100;
  endfunction

  function automatic tri_req_t rand_tri();
    tri_req_t r;
    int h, base, ys [3], k;
    bit wide;
    k = $urandom_range(0, 19);
    if (k == 0) h = $urandom_range(0, 2047);
    else if (k < 3) h = $urandom_range(60, 66);
    else h = $urandom_range(0, 30);
    base = $signed($urandom_range(0, 2047 - h)) - 1024;
    for (int i = 0; i < 3; i++) ys[i] = base + $urandom_range(0, h);
    ys[$urandom_range(0, 2)] = base;
    case ($urandom_range(0, 5))
      0: begin ys[0] = base; ys[1] = base; ys[2] = base + h; end
      1: begin ys[0] = base + h; ys[1] = base + h; ys[2] = base; end
      2: begin ys[0] = base; ys[1] = base; ys[2] = base; end
      default: ys[$urandom_range(0, 2)] = base + h;
    endcase
    wide = $urandom_range(0, 3) == 0;
    r = make_tri(rand_x(wide), ys[0], rand_x(wide), ys[1], rand_x(wide), ys[2]);
    return r;
  endfunction

  initial begin
    tri_req_t d [$];
    int wait_cycles;
    sb = new();
    cycles = 0;
    burst_left = 0;
    rst = 1'b1;
    start = 1'b0;
    first_x = '0; first_y = '0; second_x = '0; second_y = '0;
    third_x = '0; third_y = '0; fill_color = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: degenerate, flat bottom/top, general, height limit, extremes
    d.push_back(make_tri(-2048, -1024, 2047, -1024, 0, -1024));
    d.push_back(make_tri(2047, 1023, -2048, 1023, 5, 1023));
    d.push_back(make_tri(0, 0, -10, 10, 10, 10));
    d.push_back(make_tri(-10, 10, 10, 10, 0, 0));
    d.push_back(make_tri(0, 20, -30, 5, 30, 5));
    d.push_back(make_tri(30, 5, 0, 20, -30, 5));
    d.push_back(make_tri(0, 0, 40, 15, -7, 30));
    d.push_back(make_tri(-7, 30, 40, 15, 0, 0));
    d.push_back(make_tri(40, 15, -7, 30, 0, 0));
    d.push_back(make_tri(0, -1024, 100, -990, -50, -962));
    d.push_back(make_tri(0, 961, 100, 990, -50, 1023));
    d.push_back(make_tri(0, 0, 1, 31, 2, 63));
    d.push_back(make_tri(0, -1024, 0, 0, 0, 1023));
    d.push_back(make_tri(-2048, 0, 2047, 1, -2048, 2));
    d.push_back(make_tri(2047, 0, -2048, 1, 2047, 40));
    d.push_back(make_tri(-2048, 0, 2047, 0, -2048, 1));
    d.push_back(make_tri(2047, -5, 2047, 50, -2048, 50));
    d.push_back(make_tri(3, 7, 9, 7, 1, 7));
    d.push_back(make_tri(-3, 4, 8, 9, 2, 4));
    d.push_back(make_tri(1, 1, 1000, 2, -1000, 3));
    foreach (d[i]) begin
      d[i].color = (i == 0) ? '0 : (i == 1) ? '1 : d[i].color;
      send_tri(d[i]);
    end

    // random triangles
    repeat (310) send_tri(rand_tri());

    // drain
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
